// ===== hdl/isct_pkg.sv =====
// Shared types and constants of the interval sequence countdown timer.
`default_nettype none

package isct_pkg;

    // Sizing of the timer
    localparam int MAX_INTERVALS    = 4;
    localparam int TIME_BITS        = 17;
    localparam int INTERVAL_REGS    = 4;
    localparam int DEFAULT_INTERVAL = 1500;

    // Field widths of the ports
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int DUR_W       = 17;
    localparam int ELAPSED_W   = 17;
    localparam int UP_W        = 32;
    localparam int LOOPNO_W    = 9;
    localparam int ACTION_W    = 4;
    localparam int EVENT_W     = 3;
    localparam int COUNT_W     = 3;
    localparam int LOOPS_W     = 8;

    typedef logic [TIME_BITS-1:0] time_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_0   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_1   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_2   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_3   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_CNT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_CNT     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_ACT  = 3'd6;

    // Timeout action codes; each but ACT_NONE changes the timer
    localparam logic [ACTION_W-1:0] ACT_NONE     = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_SLEEP    = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_SHUTDOWN = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_RESTART  = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_SHOW     = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_COUNT_UP = 4'd7;

    typedef enum logic [1:0] {
        MODE_HALTED = 2'd0,
        MODE_CLOCK  = 2'd1,
        MODE_DOWN   = 2'd2,
        MODE_UP     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_DOWN    = 2'd1,
        OP_SESSION = 2'd2,
        OP_UP      = 2'd3
    } op_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_COUNTED  = 3'd1,
        EV_NEXT     = 3'd2,
        EV_LOOP     = 3'd3,
        EV_DONE     = 3'd4,
        EV_TIMEOUT  = 3'd5
    } event_t;

    // One result beat
    typedef struct packed {
        event_t                event_res;
        logic [ACTION_W-1:0]   action;
        logic [ELAPSED_W-1:0]  countdown_elapsed;
        logic [UP_W-1:0]       countup_elapsed;
        logic [LOOPNO_W-1:0]   loop_number;
        mode_t                 timer_mode;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/interval_sequence_countdown_timer.sv =====
// An accepted beat passes the input register, then the result register, to reach the result port;
// throughput is one beat per cycle while the skid entry is empty, set by the combinational
// update of the timer state between those two registers.
// A two-entry result buffer lets input beats keep flowing while a result waits.
// Reset (aresetn low, synchronous) halts the timer, clears all counters and the
// session, and loads the interval table and settings with their defaults.
`default_nettype none

module interval_sequence_countdown_timer
    import isct_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_op,
    input  wire logic [DUR_W-1:0]       s_duration,
    input  wire logic                   s_paused,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [EVENT_W-1:0]          m_event_res,
    output logic [ACTION_W-1:0]         m_action,
    output logic [ELAPSED_W-1:0]        m_countdown_elapsed,
    output logic [UP_W-1:0]             m_countup_elapsed,
    output logic [LOOPNO_W-1:0]         m_loop_number,
    output logic [1:0]                  m_timer_mode
);

    localparam logic [COUNT_W-1:0] MAX_USED = COUNT_W'(MAX_INTERVALS);

    // Configuration registers
    logic [CFG_DATA_W-1:0] interval_reg [INTERVAL_REGS];
    logic [COUNT_W-1:0]    interval_count_reg;
    logic [LOOPS_W-1:0]    loop_count_reg;
    logic [ACTION_W-1:0]   timeout_action_reg;

    // Timer state
    mode_t                 mode_reg, mode_next;
    time_t                 total_reg, total_next;
    time_t                 down_reg, down_next;
    logic                  seen_reg, seen_next;
    logic [UP_W-1:0]       up_reg, up_next;
    logic                  session_reg, session_next;
    logic [COUNT_W-1:0]    seq_reg, seq_next;
    logic [LOOPS_W-1:0]    loops_reg, loops_next;

    // Input stage
    logic                  in_valid_reg;
    op_t                   in_op_reg;
    logic [DUR_W-1:0]      in_dur_reg;
    logic                  in_paused_reg;

    // Result buffer
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;
    logic                  skid_valid_reg, skid_valid_next;
    result_t               skid_reg, skid_next;

    logic                  advance;
    logic                  pop;
    result_t               res;
    logic [COUNT_W-1:0]    used;
    logic                  entry_hit;
    time_t                 down_inc;
    logic [COUNT_W-1:0]    seq_inc;
    logic [LOOPS_W-1:0]    loops_inc;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && !skid_valid_reg;
    assign s_ready   = !in_valid_reg || advance;
    assign pop       = out_valid_reg && m_ready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg[0]    <= CFG_DATA_W'(1500);
            interval_reg[1]    <= CFG_DATA_W'(300);
            interval_reg[2]    <= CFG_DATA_W'(1500);
            interval_reg[3]    <= CFG_DATA_W'(900);
            interval_count_reg <= COUNT_W'(1);
            loop_count_reg     <= LOOPS_W'(1);
            timeout_action_reg <= ACT_NONE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_INTERVAL_0:   interval_reg[0]    <= cfg_data;
                CFG_INTERVAL_1:   interval_reg[1]    <= cfg_data;
                CFG_INTERVAL_2:   interval_reg[2]    <= cfg_data;
                CFG_INTERVAL_3:   interval_reg[3]    <= cfg_data;
                CFG_INTERVAL_CNT: interval_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_LOOP_CNT:     loop_count_reg     <= cfg_data[LOOPS_W-1:0];
                CFG_TIMEOUT_ACT:  timeout_action_reg <= cfg_data[ACTION_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_op_reg     <= op_t'(s_op);
            in_dur_reg    <= s_duration;
            in_paused_reg <= s_paused;
        end
    end

    // Table lookup helpers for the current interval
    assign used      = (interval_count_reg > MAX_USED) ? MAX_USED : interval_count_reg;
    assign entry_hit = (seq_reg < used) && (seq_reg < COUNT_W'(INTERVAL_REGS)) &&
                       (total_reg == TIME_BITS'(interval_reg[seq_reg[1:0]]));
    assign down_inc = down_reg + TIME_BITS'(1);
    assign seq_inc  = seq_reg + COUNT_W'(1);
    assign loops_inc = loops_reg + LOOPS_W'(1);

    // Apply one beat to the timer state
    always_comb begin
        mode_next    = mode_reg;
        total_next   = total_reg;
        down_next    = down_reg;
        seen_next    = seen_reg;
        up_next      = up_reg;
        session_next = session_reg;
        seq_next     = seq_reg;
        loops_next   = loops_reg;
        res.event_res   = EV_NONE;
        res.action      = ACT_NONE;
        res.loop_number = '0;

        case (in_op_reg)
            OP_DOWN: begin
                total_next = TIME_BITS'(in_dur_reg);
                down_next  = '0;
                seen_next  = 1'b0;
                mode_next  = MODE_DOWN;
            end
            OP_SESSION: begin
                session_next = 1'b1;
                seq_next     = '0;
                loops_next   = '0;
                total_next   = (interval_count_reg != '0) ? TIME_BITS'(interval_reg[0])
                                                          : TIME_BITS'(DEFAULT_INTERVAL);
                down_next    = '0;
                seen_next    = 1'b0;
                mode_next    = MODE_DOWN;
            end
            OP_UP: begin
                mode_next = MODE_UP;
                up_next   = '0;
            end
            default: begin
                if (!in_paused_reg && mode_reg == MODE_UP) begin
                    up_next       = up_reg + UP_W'(1);
                    res.event_res = EV_COUNTED;
                end else if (!in_paused_reg && mode_reg == MODE_DOWN &&
                             down_reg < total_reg) begin
                    down_next = down_inc;
                    if (down_inc < total_reg || seen_reg) begin
                        res.event_res = EV_COUNTED;
                    end else if (session_reg && used != '0 && entry_hit) begin
                        // Interval finished inside a session: advance the table, or end the session after the last loop
                        if (seq_inc >= used) begin
                            seq_next   = '0;
                            loops_next = loops_inc;
                        end else begin
                            seq_next = seq_inc;
                        end
                        if (seq_inc >= used && loops_inc >= loop_count_reg) begin
                            down_next     = '0;
                            seen_next     = 1'b0;
                            total_next    = '0;
                            session_next  = 1'b0;
                            mode_next     = MODE_HALTED;
                            res.event_res = EV_DONE;
                        end else begin
                            total_next = (seq_inc >= used) ? TIME_BITS'(interval_reg[0])
                                       : TIME_BITS'(interval_reg[seq_inc[1:0]]);
                            down_next  = '0;
                            seen_next  = 1'b0;
                            if (seq_inc >= used && loops_inc != '0) begin
                                res.loop_number = LOOPNO_W'(loops_inc) + LOOPNO_W'(1);
                                res.event_res   = EV_LOOP;
                            end else begin
                                res.event_res = EV_NEXT;
                            end
                        end
                    end else begin
                        // Plain timeout: report the action, drop a stale session
                        seen_next     = 1'b1;
                        res.action    = timeout_action_reg;
                        res.event_res = EV_TIMEOUT;
                        if (session_reg && !entry_hit) begin
                            session_next = 1'b0;
                            seq_next     = '0;
                            loops_next   = '0;
                        end
                        case (timeout_action_reg) inside
                            ACT_SLEEP, ACT_SHUTDOWN, ACT_RESTART: begin
                                total_next = '0;
                                down_next  = '0;
                                mode_next  = MODE_HALTED;
                            end
                            ACT_SHOW: begin
                                mode_next = MODE_CLOCK;
                            end
                            ACT_COUNT_UP: begin
                                mode_next = MODE_UP;
                                up_next   = '0;
                                seen_next = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
        endcase

        res.countdown_elapsed = ELAPSED_W'(down_next);
        res.countup_elapsed   = up_next;
        res.timer_mode        = mode_next;
    end

    // Hold the timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_HALTED;
            total_reg   <= '0;
            down_reg    <= '0;
            seen_reg    <= 1'b0;
            up_reg      <= '0;
            session_reg <= 1'b0;
            seq_reg     <= '0;
            loops_reg   <= '0;
        end else if (advance) begin
            mode_reg    <= mode_next;
            total_reg   <= total_next;
            down_reg    <= down_next;
            seen_reg    <= seen_next;
            up_reg      <= up_next;
            session_reg <= session_next;
            seq_reg     <= seq_next;
            loops_reg   <= loops_next;
        end
    end

    // Steer results through the output register and its skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = advance;
                skid_next       = res;
            end else begin
                out_valid_next = advance;
                out_next       = res;
            end
        end else if (advance) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid             = out_valid_reg;
    assign m_event_res         = out_reg.event_res;
    assign m_action            = out_reg.action;
    assign m_countdown_elapsed = out_reg.countdown_elapsed;
    assign m_countup_elapsed   = out_reg.countup_elapsed;
    assign m_loop_number       = out_reg.loop_number;
    assign m_timer_mode        = out_reg.timer_mode;

`ifndef NO_ASSERTIONS
    // The skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output register");

    // A finished session always leaves the timer halted
    a_done_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_DONE) |-> (m_timer_mode == MODE_HALTED))
        else $error("session complete without halt");

    // An action is reported only with a timeout
    a_action_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res != EV_TIMEOUT) |-> (m_action == ACT_NONE))
        else $error("action outside timeout");

    // A loop number comes with a new loop and only then
    a_loop_number: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_event_res == EV_LOOP) == (m_loop_number != '0)))
        else $error("loop number mismatch");

    // The table position never runs past MAX_USED
    a_seq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg <= MAX_USED)
        else $error("sequence index out of range");
`endif

endmodule

`default_nettype wire
